// ===== hdl/ntc_pkg.sv =====
// ntc_pkg: beat types, field widths and codes shared by the tint classifier
// used by ntc_cell and nearest_tint_classifier; no dependencies
package ntc_pkg;

	localparam int ENTRY_W = 6;
	localparam int COLOR_W = 32;
	localparam int DIST_W  = 18;
	localparam int KIND_W  = 2;
	localparam int COUNT_W = 7;
	localparam int CHAN_W  = 8;
	localparam int CHAN_SQ_W = 16;

	localparam logic [CHAN_W-1:0] ALPHA_OPAQUE = 8'hFF;

	localparam logic MODE_LOAD     = 1'b0;
	localparam logic MODE_CLASSIFY = 1'b1;

	localparam logic [KIND_W-1:0] KIND_NONE    = 2'd0;
	localparam logic [KIND_W-1:0] KIND_EXACT   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_NEAREST = 2'd2;

	typedef struct packed {
		logic               mode;
		logic [ENTRY_W-1:0] entry_index;
		logic               entry_valid;
		logic [COLOR_W-1:0] color;
	} pix_beat_t;

	typedef struct packed {
		logic [ENTRY_W-1:0] material_index;
		logic [KIND_W-1:0]  match_kind;
		logic [DIST_W-1:0]  best_distance;
	} res_beat_t;

	// item in flight along the cell row, with the running search result
	typedef struct packed {
		logic               valid;
		pix_beat_t          beat;
		logic               exact_hit;
		logic [ENTRY_W-1:0] exact_index;
		logic               near_hit;
		logic [ENTRY_W-1:0] near_index;
		logic [DIST_W-1:0]  near_dist;
	} token_t;

endpackage

// ===== hdl/nearest_tint_classifier.sv =====
// nearest_tint_classifier: row of entry cells matching pixels to stored tints
// depends on ntc_pkg and ntc_cell
//
//   port group   dir  beat
//   pix          in   pix_beat_t: load one entry or classify one pixel
//   res          out  res_beat_t: one per classified pixel, none per load
//   cfg          in   type_count, taken at once
//
// one beat enters per cycle while pix_ready is high; res_valid rises once the beat has passed every cell stage
// loads travel the row in order with pixels, so no beat sees a later write
// reset clears all entry valid bits, the row and type_count
// a stalled result holds the whole row and pix_ready drops
module nearest_tint_classifier #(
	parameter int MAX_TYPES = 64
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  ntc_pkg::pix_beat_t          pix,
	output logic                        res_valid,
	input  logic                        res_ready,
	output ntc_pkg::res_beat_t          res,
	input  logic                        cfg_valid,
	output logic                        cfg_ready,
	input  logic [ntc_pkg::COUNT_W-1:0] cfg_data
);

	logic                        advance;
	logic [ntc_pkg::COUNT_W-1:0] type_count_q;
	ntc_pkg::token_t             chain [MAX_TYPES+1];
	ntc_pkg::token_t             last;
	ntc_pkg::res_beat_t          res_nxt;
	logic                        res_valid_q;
	ntc_pkg::res_beat_t          res_q;

	assign advance   = !res_valid_q || res_ready;
	assign pix_ready = advance;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			type_count_q <= '0;
		end else if (cfg_valid) begin
			type_count_q <= cfg_data;
		end
	end

	always_comb begin
		chain[0]             = '0;
		chain[0].valid       = pix_valid;
		chain[0].beat        = pix;
	end

	for (genvar i = 0; i < MAX_TYPES; i++) begin : g_cell
		ntc_cell #(
			.INDEX (i)
		) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.advance    (advance),
			.type_count (type_count_q),
			.tok        (chain[i]),
			.tok_s1     (chain[i+1])
		);
	end

	assign last = chain[MAX_TYPES];

	always_comb begin
		res_nxt = '0;
		if (last.exact_hit) begin
			res_nxt.material_index = last.exact_index;
			res_nxt.match_kind     = ntc_pkg::KIND_EXACT;
		end else if (last.near_hit) begin
			res_nxt.material_index = last.near_index;
			res_nxt.match_kind     = ntc_pkg::KIND_NEAREST;
			res_nxt.best_distance  = last.near_dist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (advance) begin
			res_valid_q <= last.valid && (last.beat.mode == ntc_pkg::MODE_CLASSIFY);
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_q <= res_nxt;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

endmodule

// ===== hdl/ntc_cell.sv =====
// ntc_cell: one table entry of the tint classifier and its search stage
// depends on ntc_pkg for the token type, widths and codes
module ntc_cell #(
	parameter int INDEX = 0
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            advance,
	input  logic [ntc_pkg::COUNT_W-1:0]     type_count,
	input  ntc_pkg::token_t                 tok,
	output ntc_pkg::token_t                 tok_s1
);

	localparam logic [ntc_pkg::ENTRY_W-1:0] SLOT = ntc_pkg::ENTRY_W'(INDEX);
	localparam logic [8:0] POS = 9'(INDEX);
	localparam logic WRITABLE = (INDEX < (1 << ntc_pkg::ENTRY_W));

	logic [3*ntc_pkg::CHAN_W-1:0] tint_q;
	logic                         present_q;

	logic                         active;
	logic                         is_load;
	logic                         exact;
	logic [ntc_pkg::CHAN_W-1:0]   dr, dg, db;
	logic [ntc_pkg::CHAN_SQ_W-1:0] sr, sg, sb;
	logic [ntc_pkg::DIST_W-1:0]   sq_dist;
	logic                         closer;
	ntc_pkg::token_t              nxt;
	logic                         valid_s1;
	ntc_pkg::token_t              payload_s1;

	function automatic logic [ntc_pkg::CHAN_W-1:0] abs_diff(
		input logic [ntc_pkg::CHAN_W-1:0] a,
		input logic [ntc_pkg::CHAN_W-1:0] b
	);
		return (a > b) ? (a - b) : (b - a);
	endfunction

	assign is_load = tok.valid && (tok.beat.mode == ntc_pkg::MODE_LOAD);
	assign active  = present_q && (POS < {2'b00, type_count});

	assign exact = active &&
		({ntc_pkg::ALPHA_OPAQUE, tint_q} == tok.beat.color);

	assign dr = abs_diff(tok.beat.color[7:0],   tint_q[7:0]);
	assign dg = abs_diff(tok.beat.color[15:8],  tint_q[15:8]);
	assign db = abs_diff(tok.beat.color[23:16], tint_q[23:16]);
	assign sr = dr * dr;
	assign sg = dg * dg;
	assign sb = db * db;
	assign sq_dist = ntc_pkg::DIST_W'(sr) + ntc_pkg::DIST_W'(sg) + ntc_pkg::DIST_W'(sb);
	assign closer = active && (!tok.near_hit || (sq_dist < tok.near_dist));

	always_comb begin
		nxt = tok;
		if (exact && !tok.exact_hit) begin
			nxt.exact_hit   = 1'b1;
			nxt.exact_index = SLOT;
		end
		if (closer) begin
			nxt.near_hit   = 1'b1;
			nxt.near_index = SLOT;
			nxt.near_dist  = sq_dist;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			present_q <= 1'b0;
		end else if (advance && is_load && WRITABLE && (tok.beat.entry_index == SLOT)) begin
			present_q <= tok.beat.entry_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && is_load && WRITABLE && (tok.beat.entry_index == SLOT)) begin
			tint_q <= tok.beat.color[3*ntc_pkg::CHAN_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (advance) begin
			valid_s1 <= tok.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			payload_s1 <= nxt;
		end
	end

	always_comb begin
		tok_s1       = payload_s1;
		tok_s1.valid = valid_s1;
	end

endmodule
